@@ sv/dmc_pkg.sv @@
package dmc_pkg;

  localparam int ADDR_BITS       = 40;
  localparam int MAX_LINES       = 1024;
  localparam int MAX_OFFSET_BITS = 12;
  localparam int MAX_INDEX_BITS  = $clog2(MAX_LINES + 1) - 1;

  localparam int DISP_W = 12;
  localparam int LINE_W = 10;
  localparam int TAG_W  = ADDR_BITS;
  localparam int CNT_W  = 32;
  localparam int CYC_W  = 48;
  localparam int CFG_W  = 8;
  localparam int NLINES = 1 << MAX_INDEX_BITS;

  localparam logic [3:0] OFFSET_BITS_RST = 4'd4;
  localparam logic [3:0] INDEX_BITS_RST  = 4'd6;
  localparam logic [3:0] CACHE_TIME_RST  = 4'd1;
  localparam logic [7:0] MEMORY_TIME_RST = 8'd100;

  typedef enum logic [1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_INDEX_BITS  = 2'd1,
    REG_CACHE_TIME  = 2'd2,
    REG_MEMORY_TIME = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMPARE
  } state_t;

  typedef struct packed {
    logic clear;   // invalidate one line, advance sweep
    logic load;    // capture request, issue tag read
    logic commit;  // compare, fill on miss, update counters and result
  } dmc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dmc_status_t;

endpackage

@@ sv/dmc_if.sv @@
interface dmc_req_if;
  import dmc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;

  modport source(output valid, output address, input ready);
  modport sink(input valid, input address, output ready);
endinterface

interface dmc_rsp_if;
  import dmc_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [DISP_W-1:0] displacement;
  logic [LINE_W-1:0] line_index;
  logic [TAG_W-1:0]  tag_value;
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  miss_count;
  logic [CNT_W-1:0]  access_count;
  logic [CYC_W-1:0]  total_cycles;

  modport source(output valid, output hit, output displacement, output line_index,
                 output tag_value, output hit_count, output miss_count,
                 output access_count, output total_cycles, input ready);
  modport sink(input valid, input hit, input displacement, input line_index,
               input tag_value, input hit_count, input miss_count,
               input access_count, input total_cycles, output ready);
endinterface

@@ sv/dmc_ctrl.sv @@
module dmc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmc_pkg::dmc_status_t status,
  output dmc_pkg::dmc_cmd_t    cmd
);
  import dmc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ sv/dmc_datapath.sv @@
module dmc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [dmc_pkg::CFG_W-1:0]   cfg_data,
  input  logic [dmc_pkg::ADDR_BITS-1:0] address,
  input  dmc_pkg::dmc_cmd_t           cmd,
  output dmc_pkg::dmc_status_t        status,
  dmc_rsp_if.source                   rsp
);
  import dmc_pkg::*;

  // configuration
  logic [3:0] offset_bits, index_bits, cache_time;
  logic [7:0] memory_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      index_bits  <= INDEX_BITS_RST;
      cache_time  <= CACHE_TIME_RST;
      memory_time <= MEMORY_TIME_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFFSET_BITS: offset_bits <= cfg_data[3:0];
        REG_INDEX_BITS:  index_bits  <= cfg_data[3:0];
        REG_CACHE_TIME:  cache_time  <= cfg_data[3:0];
        REG_MEMORY_TIME: memory_time <= cfg_data[7:0];
      endcase
    end
  end

  // address split
  logic [3:0]        ob_c, ib_c;
  logic [4:0]        tag_shift;
  logic [DISP_W-1:0] disp_c;
  logic [LINE_W-1:0] idx_c;
  logic [TAG_W-1:0]  tag_c, shifted;

  always_comb begin
    ob_c      = (offset_bits > 4'(MAX_OFFSET_BITS)) ? 4'(MAX_OFFSET_BITS) : offset_bits;
    ib_c      = (index_bits > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS) : index_bits;
    tag_shift = {1'b0, ob_c} + {1'b0, ib_c};
    disp_c    = address[DISP_W-1:0] & ~({DISP_W{1'b1}} << ob_c);
    shifted   = address >> ob_c;
    idx_c     = shifted[LINE_W-1:0] & ~({LINE_W{1'b1}} << ib_c);
    tag_c     = address >> tag_shift;
  end

  // captured request
  logic [DISP_W-1:0] disp_r;
  logic [LINE_W-1:0] idx_r;
  logic [TAG_W-1:0]  tag_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      disp_r <= disp_c;
      idx_r  <= idx_c;
      tag_r  <= tag_c;
    end
  end

  // tag store: {valid, tag} per line
  logic [TAG_W:0]    line_mem [NLINES];
  logic [TAG_W:0]    rd_data;
  logic [LINE_W-1:0] clear_idx;
  logic              hit_c;
  logic              mem_we;
  logic [LINE_W-1:0] mem_waddr;
  logic [TAG_W:0]    mem_wdata;

  assign hit_c     = rd_data[TAG_W] && (rd_data[TAG_W-1:0] == tag_r);
  assign mem_we    = cmd.clear || (cmd.commit && !hit_c);
  assign mem_waddr = cmd.clear ? clear_idx : idx_r;
  assign mem_wdata = cmd.clear ? '0 : {1'b1, tag_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.load) begin
      rd_data <= line_mem[idx_c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx <= '0;
    end else if (cmd.clear) begin
      clear_idx <= clear_idx + 1'b1;
    end
  end

  // counters and result register
  logic             out_valid;
  logic             hit_q;
  logic [DISP_W-1:0] disp_q;
  logic [LINE_W-1:0] idx_q;
  logic [TAG_W-1:0]  tag_q;
  logic [CNT_W-1:0]  hits, misses, accesses;
  logic [CYC_W-1:0]  cycles;
  logic [8:0]        cost;
  logic [CYC_W:0]    cyc_sum;

  assign cost    = {5'd0, cache_time} + (hit_c ? 9'd0 : {1'b0, memory_time});
  assign cyc_sum = {1'b0, cycles} + (CYC_W + 1)'(cost);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hits      <= '0;
      misses    <= '0;
      accesses  <= '0;
      cycles    <= '0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
      if (hit_c) begin
        if (hits != '1) hits <= hits + 1'b1;
      end else begin
        if (misses != '1) misses <= misses + 1'b1;
      end
      if (accesses != '1) accesses <= accesses + 1'b1;
      cycles <= cyc_sum[CYC_W] ? '1 : cyc_sum[CYC_W-1:0];
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_q  <= hit_c;
      disp_q <= disp_r;
      idx_q  <= idx_r;
      tag_q  <= tag_r;
    end
  end

  assign status.clear_last = (clear_idx == '1);
  assign status.out_free   = !out_valid || rsp.ready;

  assign rsp.valid        = out_valid;
  assign rsp.hit          = hit_q;
  assign rsp.displacement = disp_q;
  assign rsp.line_index   = idx_q;
  assign rsp.tag_value    = tag_q;
  assign rsp.hit_count    = hits;
  assign rsp.miss_count   = misses;
  assign rsp.access_count = accesses;
  assign rsp.total_cycles = cycles;

endmodule

@@ sv/direct_mapped_cache_lookup.sv @@
// One request at a time: it is accepted in idle, which registers its fields
//   and reads the tag RAM; the compare step then checks the tag, fills the
//   line on a miss and loads the result register, once any held result is taken.
// Reset (synchronous, rst high): config to defaults, counters to zero, then a
//   sweep clears every line's valid bit; req.ready stays low meanwhile.
module direct_mapped_cache_lookup (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [dmc_pkg::CFG_W-1:0] cfg_data,
  dmc_req_if.sink                   req,
  dmc_rsp_if.source                 rsp
);
  import dmc_pkg::*;

  dmc_cmd_t    cmd;
  dmc_status_t status;

  // Controller: sweep -> idle -> compare. Accepts a new request only in idle;
  // a pending result in the output register does not block acceptance, only
  // the commit of the next one.
  dmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: address split from the live config, tag RAM with valid bit,
  // saturating counters, and the result register feeding rsp.
  dmc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .address   (req.address),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp)
  );

  // no request taken while the valid sweep is running
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !req.ready)
    else $error("request accepted during valid sweep");

  // every commit presents a result on the next cycle
  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("commit without result");

  // accesses split exactly into hits and misses until saturation
  a_count_balance: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (rsp.access_count == '1) ||
      ({1'b0, rsp.access_count} ==
       ({1'b0, rsp.hit_count} + {1'b0, rsp.miss_count})))
    else $error("hit and miss counts disagree with access count");

  // a load is always followed by the compare state, never by another load
  a_load_then_compare: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !cmd.load && !req.ready)
    else $error("second request taken before compare");

endmodule
